>>> hdl/lfuc_pkg.sv
// Shared constants and sequencer state type for the LFU cache table.
package lfuc_pkg;

  // Capacity register width and reset value
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  // Request type codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Read value returned on a get miss
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } seq_state_t;

endpackage

>>> hdl/lfu_cache_table.sv
// LFU cache table with LRU tie break, slot memory swept by a small sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in_     | input     | in_valid / in_stall    | in_req_type, in_key, in_value
//  out_    | output    | out_valid / out_stall  | out_hit, out_read_value, out_evicted
//  cfg_    | input     | cfg_wr_en              | cfg_wr_data (capacity_in_use)
//
// A transaction runs: accept, key/victim scan, decide, then for a hit or an insert
// a rank/count update sweep, then result; each sweep visits one slot per cycle.
// Synchronous active-low reset clears valid bits, occupancy and control; no
// clearing pass is needed. in_stall is high from acceptance until the result
// is loaded into the output register; a stalled output holds the next result back.
module lfu_cache_table #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [lfuc_pkg::CAP_W-1:0] cfg_wr_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic signed [31:0]        in_key,
  input  logic signed [31:0]        in_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic signed [31:0]        out_read_value,
  output logic                      out_evicted
);

  import lfuc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RW = IW;
  localparam int unsigned UW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (UW > CAP_W) ? UW : CAP_W;
  localparam logic [IW-1:0]         LAST_IDX  = IW'(ENTRIES - 1);
  localparam logic [IW:0]           CNT_END   = (IW + 1)'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef struct packed {
    logic [31:0]           key;
    logic [31:0]           value;
    logic [COUNT_BITS-1:0] cnt;
    logic [RW-1:0]         rank;
  } slot_t;

  // Slot memory and per-slot valid bits
  slot_t              slot_mem_r [ENTRIES];
  slot_t              rd_q_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [UW-1:0]      used_r, used_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;

  seq_state_t    state_r, state_nxt;
  logic [IW:0]   cnt_r, cnt_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic [IW-1:0] p_idx_r, p_idx_nxt;

  // Request held for the whole transaction
  logic          put_r, put_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   val_r, val_nxt;

  // Scan results
  logic                  m_fnd_r, m_fnd_nxt;
  logic [IW-1:0]         m_idx_r, m_idx_nxt;
  logic [RW-1:0]         m_rank_r, m_rank_nxt;
  logic [31:0]           m_val_r, m_val_nxt;
  logic                  v_fnd_r, v_fnd_nxt;
  logic [IW-1:0]         v_idx_r, v_idx_nxt;
  logic [COUNT_BITS-1:0] v_cnt_r, v_cnt_nxt;
  logic [RW-1:0]         v_rank_r, v_rank_nxt;
  logic                  f_fnd_r, f_fnd_nxt;
  logic [IW-1:0]         f_idx_r, f_idx_nxt;

  // Update plan
  logic          ins_r, ins_nxt;
  logic          ev_r, ev_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [31:0]   out_rd_r, out_rd_nxt;
  logic          out_ev_r, out_ev_nxt;

  // Memory port signals
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_t         wr_data;

  // Effective capacity and occupancy check
  logic [CW-1:0] cap_ext, cap_eff, used_ext;
  logic          full;
  logic          p_valid;

  assign cap_ext  = CW'(cap_r);
  assign cap_eff  = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
  assign used_ext = CW'(used_r);
  assign full     = (used_ext >= cap_eff);
  assign p_valid  = valid_r[p_idx_r];

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_rd_r;
  assign out_evicted    = out_ev_r;

  // Sequencer, scan unit and update unit
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    p_vld_nxt  = 1'b0;
    p_idx_nxt  = p_idx_r;
    put_nxt    = put_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    m_fnd_nxt  = m_fnd_r;
    m_idx_nxt  = m_idx_r;
    m_rank_nxt = m_rank_r;
    m_val_nxt  = m_val_r;
    v_fnd_nxt  = v_fnd_r;
    v_idx_nxt  = v_idx_r;
    v_cnt_nxt  = v_cnt_r;
    v_rank_nxt = v_rank_r;
    f_fnd_nxt  = f_fnd_r;
    f_idx_nxt  = f_idx_r;
    ins_nxt    = ins_r;
    ev_nxt     = ev_r;
    valid_nxt  = valid_r;
    used_nxt   = used_r;
    cap_nxt    = cfg_wr_en ? cfg_wr_data : cap_r;
    rd_en      = 1'b0;
    rd_addr    = cnt_r[IW-1:0];
    wr_en      = 1'b0;
    wr_addr    = p_idx_r;
    wr_data    = rd_q_r;

    // output register drains independently of the sequencer
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_rd_nxt    = out_rd_r;
    out_ev_nxt    = out_ev_r;

    // slot read issue during sweeps
    if ((state_r == ST_SCAN || state_r == ST_UPDATE) && cnt_r < CNT_END) begin
      rd_en     = 1'b1;
      p_vld_nxt = 1'b1;
      p_idx_nxt = cnt_r[IW-1:0];
      cnt_nxt   = cnt_r + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          put_nxt   = (in_req_type == REQ_PUT);
          key_nxt   = in_key;
          val_nxt   = in_value;
          cnt_nxt   = '0;
          m_fnd_nxt = 1'b0;
          v_fnd_nxt = 1'b0;
          f_fnd_nxt = 1'b0;
          ev_nxt    = 1'b0;
          ins_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (p_vld_r) begin
          // key match
          if (p_valid && rd_q_r.key == key_r && !m_fnd_r) begin
            m_fnd_nxt  = 1'b1;
            m_idx_nxt  = p_idx_r;
            m_rank_nxt = rd_q_r.rank;
            m_val_nxt  = rd_q_r.value;
          end
          // victim: lowest count, oldest on a tie
          if (p_valid && (!v_fnd_r || rd_q_r.cnt < v_cnt_r ||
              (rd_q_r.cnt == v_cnt_r && rd_q_r.rank > v_rank_r))) begin
            v_fnd_nxt  = 1'b1;
            v_idx_nxt  = p_idx_r;
            v_cnt_nxt  = rd_q_r.cnt;
            v_rank_nxt = rd_q_r.rank;
          end
          // first free slot
          if (!p_valid && !f_fnd_r) begin
            f_fnd_nxt = 1'b1;
            f_idx_nxt = p_idx_r;
          end
          if (p_idx_r == LAST_IDX) begin
            cnt_nxt   = '0;
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (put_r && cap_eff == '0) begin
          // zero capacity put changes nothing
          state_nxt = ST_DONE;
        end else if (m_fnd_r) begin
          ins_nxt   = 1'b0;
          state_nxt = ST_UPDATE;
        end else if (put_r) begin
          ins_nxt = 1'b1;
          if (full) begin
            ev_nxt = 1'b1;
            valid_nxt[v_idx_r] = 1'b0;
            // new slot is the lowest free index once the victim is gone
            if (!(f_fnd_r && f_idx_r < v_idx_r))
              f_idx_nxt = v_idx_r;
            valid_nxt[(f_fnd_r && f_idx_r < v_idx_r) ? f_idx_r : v_idx_r] = 1'b1;
          end else begin
            valid_nxt[f_idx_r] = 1'b1;
            used_nxt = used_r + 1'b1;
          end
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_UPDATE: begin
        if (p_vld_r) begin
          if (ins_r) begin
            if (p_idx_r == f_idx_r) begin
              wr_en         = 1'b1;
              wr_data.key   = key_r;
              wr_data.value = val_r;
              wr_data.cnt   = COUNT_ONE;
              wr_data.rank  = '0;
            end else if (p_valid) begin
              // older than the victim moves up one, then all age by one
              wr_en        = 1'b1;
              wr_data.rank = rd_q_r.rank + 1'b1 -
                             ((ev_r && rd_q_r.rank > v_rank_r) ? 1'b1 : 1'b0);
            end
          end else begin
            if (p_idx_r == m_idx_r) begin
              wr_en        = 1'b1;
              wr_data.rank = '0;
              if (put_r)
                wr_data.value = val_r;
              if (rd_q_r.cnt != COUNT_MAX)
                wr_data.cnt = rd_q_r.cnt + 1'b1;
            end else if (p_valid && rd_q_r.rank < m_rank_r) begin
              wr_en        = 1'b1;
              wr_data.rank = rd_q_r.rank + 1'b1;
            end
          end
          if (p_idx_r == LAST_IDX)
            state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = m_fnd_r;
          out_ev_nxt    = ev_r;
          if (put_r)
            out_rd_nxt = '0;
          else
            out_rd_nxt = m_fnd_r ? m_val_r : MISS_VALUE;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Slot memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (rd_en)
      rd_q_r <= slot_mem_r[rd_addr];
    if (wr_en)
      slot_mem_r[wr_addr] <= wr_data;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
      valid_r     <= '0;
      used_r      <= '0;
      cap_r       <= CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    p_idx_r  <= p_idx_nxt;
    put_r    <= put_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    m_fnd_r  <= m_fnd_nxt;
    m_idx_r  <= m_idx_nxt;
    m_rank_r <= m_rank_nxt;
    m_val_r  <= m_val_nxt;
    v_fnd_r  <= v_fnd_nxt;
    v_idx_r  <= v_idx_nxt;
    v_cnt_r  <= v_cnt_nxt;
    v_rank_r <= v_rank_nxt;
    f_fnd_r  <= f_fnd_nxt;
    f_idx_r  <= f_idx_nxt;
    ins_r    <= ins_nxt;
    ev_r     <= ev_nxt;
    out_hit_r <= out_hit_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ev_r  <= out_ev_nxt;
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the LFU cache table: directed, random and back-pressure tests.
module tb;
  import lfuc_pkg::*;

  localparam int unsigned SLOTS = 16;
  // Narrow use counts so that saturation is reached within a short run
  localparam int unsigned CNT_W = 3;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
  } cache_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_req_type;
  logic [31:0]      in_key;
  logic [31:0]      in_value;
  logic             out_valid;
  logic             out_stall;
  logic             out_hit;
  logic [31:0]      out_read_value;
  logic             out_evicted;

  lfu_cache_table #(
    .ENTRIES   (SLOTS),
    .COUNT_BITS(CNT_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .out_evicted   (out_evicted)
  );

  // Shadow copy of the cache table
  bit               m_valid [SLOTS];
  logic [31:0]      m_key   [SLOTS];
  logic [31:0]      m_val   [SLOTS];
  logic [CNT_W-1:0] m_cnt   [SLOTS];
  int unsigned      m_rank  [SLOTS];
  int unsigned      m_used;
  logic [CAP_W-1:0] m_cap;

  cache_result_t due_results[$];
  int unsigned   err_count;
  int unsigned   in_gap_max;
  int unsigned   out_gap_max;
  int unsigned   hold_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Make slot s the most recent and count one use
  function automatic void promote_slot(int s);
    for (int i = 0; i < SLOTS; i++) begin
      if (m_valid[i] && m_rank[i] < m_rank[s]) m_rank[i]++;
    end
    m_rank[s] = 0;
    if (m_cnt[s] != CNT_TOP) m_cnt[s]++;
  endfunction

  // Expected result of one request; updates the shadow table
  function automatic cache_result_t predict_request(logic kind, logic [31:0] k,
                                                     logic [31:0] v);
    cache_result_t r;
    int            s;
    int            victim;
    int            free_slot;
    int unsigned   cap;
    cap = (m_cap < SLOTS) ? m_cap : SLOTS;
    s = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (s < 0 && m_valid[i] && m_key[i] == k) s = i;
    end
    r.hit        = (s >= 0);
    r.read_value = '0;
    r.evicted    = 1'b0;
    if (kind == REQ_GET) begin
      if (s >= 0) begin
        r.read_value = m_val[s];
        promote_slot(s);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (cap != 0) begin
      if (s >= 0) begin
        m_val[s] = v;
        promote_slot(s);
      end else begin
        // full: drop lowest count, least recent on a tie
        if (m_used >= cap) begin
          victim = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (m_valid[i] && (victim < 0 || m_cnt[i] < m_cnt[victim] ||
                (m_cnt[i] == m_cnt[victim] && m_rank[i] > m_rank[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            m_valid[victim] = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
              if (m_valid[i] && m_rank[i] > m_rank[victim]) m_rank[i]--;
            end
            if (m_used > 0) m_used--;
          end
          r.evicted = 1'b1;
        end
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (free_slot < 0 && !m_valid[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (m_valid[i]) m_rank[i]++;
          end
          m_valid[free_slot] = 1'b1;
          m_key[free_slot]   = k;
          m_val[free_slot]   = v;
          m_cnt[free_slot]   = CNT_W'(1);
          m_rank[free_slot]  = 0;
          m_used++;
        end
      end
    end
    return r;
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(logic kind, logic [31:0] k, logic [31:0] v);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_key      <= k;
    in_value    <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    due_results.push_back(predict_request(kind, k, v));
  endtask

  // Let the block empty out with the input channel quiet
  task automatic drain;
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    m_cap = c;
  endtask

  // Result checker and receiver idling
  initial begin
    int unsigned   n;
    cache_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      n = $urandom_range(0, out_gap_max);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_stall === 1'b0)) begin
        // long hold-off to back the block up
        if (hold_cycles != 0) begin
          out_stall <= 1'b1;
          repeat (hold_cycles) @(posedge clk);
          hold_cycles = 0;
          out_stall <= 1'b0;
        end
        @(posedge clk);
      end
      if (due_results.size() == 0) begin
        $error("unexpected result: hit %0d read_value %h evicted %0d",
               out_hit, out_read_value, out_evicted);
        err_count++;
      end else begin
        want = due_results.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit: expected %0d, got %0d", want.hit, out_hit);
          err_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("out_read_value: expected %h, got %h", want.read_value, out_read_value);
          err_count++;
        end
        if (out_evicted !== want.evicted) begin
          $error("out_evicted: expected %0d, got %0d", want.evicted, out_evicted);
          err_count++;
        end
      end
    end
  end

  // Field extremes, eviction order, shrunk capacity, saturation, zero capacity
  task automatic test_directed;
    send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    // three entries held, capacity now two
    set_capacity(5'd2);
    send_request(REQ_PUT, 32'h0000_0001, 32'h1234_5678);
    send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(REQ_PUT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
    send_request(REQ_PUT, 32'h0000_0002, 32'h5A5A_5A5A);
    // hammer one key past the count ceiling
    repeat (8) send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
    set_capacity(5'd0);
    send_request(REQ_PUT, 32'h0000_0003, 32'h0000_0003);
    send_request(REQ_PUT, 32'h0000_0001, 32'hDEAD_BEEF);
    send_request(REQ_GET, 32'h0000_0003, 32'h0000_0000);
    set_capacity(5'd31);
    send_request(REQ_PUT, 32'h0000_0004, 32'h0000_0004);
  endtask

  // Random gets and puts over a small key pool so that hits and evictions are common
  task automatic test_random_phase(logic [CAP_W-1:0] c, int unsigned n, int unsigned gap);
    logic [31:0] pool[$];
    logic [31:0] k;
    int unsigned pool_size;
    set_capacity(c);
    in_gap_max  = gap;
    out_gap_max = gap;
    pool_size = $urandom_range(2, 24);
    repeat (pool_size) pool.push_back($urandom);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = pool[$urandom_range(0, pool_size - 1)];
      send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, k, $urandom);
    end
    in_gap_max  = 16;
    out_gap_max = 16;
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure;
    drain();
    in_gap_max  = 0;
    hold_cycles = 400;
    repeat (12) send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET,
                             {28'h0, 4'($urandom_range(0, 5))}, $urandom);
    in_gap_max = 16;
  endtask

  // Stimulus sequence
  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_GET;
    in_key      <= '0;
    in_value    <= '0;
    out_stall   <= 1'b0;
    err_count   = 0;
    in_gap_max  = 16;
    out_gap_max = 16;
    hold_cycles = 0;
    m_used      = 0;
    m_cap       = CAP_RST;
    foreach (m_valid[i]) m_valid[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(5'd16, 70, 16);
    test_random_phase(5'd1,  60, 16);
    test_random_phase(5'd31, 70, 0);
    test_random_phase(5'd5,  70, 16);
    test_random_phase(5'd0,  40, 4);
    test_random_phase(5'd3,  70, 16);
    test_backpressure();
    test_random_phase(5'd17, 70, 16);
    test_random_phase(5'($urandom_range(1, 15)), 70, 16);
    test_random_phase(5'd8,  70, 2);

    drain();
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
